// ===== rtl/b64d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package b64d_pkg;

  // Result status codes.
  localparam logic [1:0] STS_DATA    = 2'd0;
  localparam logic [1:0] STS_INVALID = 2'd1;
  localparam logic [1:0] STS_BADPAD  = 2'd2;
  localparam logic [1:0] STS_LENGTH  = 2'd3;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Default depth of the job queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;
  } out_t;

  // One job: up to three results caused by one request.
  typedef struct packed {
    logic [1:0]  nres;
    logic [1:0]  status;
    logic [23:0] data;
  } job_t;

  // Bit 6 set means the character is not in the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) r = {1'b0, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2B) r = 7'd62;
    else if (c == 8'h2F) r = 7'd63;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/b64d_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module b64d_front
  import b64d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic take,
  input  wire in_t  item,
  output job_t      job,
  output logic      job_push
);

  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [2:0]  dchars_r, dchars_nxt;
  logic        pad_r, pad_nxt;
  logic        drop_r, drop_nxt;

  logic [6:0]  sx;
  logic        is_pad;
  logic        fin;
  logic [23:0] acc_pad;
  logic [23:0] acc_dat;

  always_comb begin
    sx      = sextet_of(item.char_code);
    is_pad  = (item.char_code == PAD_CHAR);
    fin     = item.text_end;
    acc_pad = {acc_r[17:0], 6'd0};
    acc_dat = {acc_r[17:0], sx[5:0]};

    acc_nxt    = acc_r;
    pos_nxt    = pos_r;
    dchars_nxt = dchars_r;
    pad_nxt    = pad_r;
    drop_nxt   = drop_r;
    job        = '0;
    job_push   = 1'b0;

    if (take) begin
      if (drop_r) begin
        if (fin) begin
          drop_nxt   = 1'b0;
          acc_nxt    = '0;
          pos_nxt    = '0;
          dchars_nxt = '0;
          pad_nxt    = 1'b0;
        end
      end else begin
        if (is_pad) begin
          if (pos_r < 2'd2) begin
            job_push   = 1'b1;
            job.status = STS_BADPAD;
          end else if (pos_r == 2'd2) begin
            if (fin) begin
              job_push   = 1'b1;
              job.status = STS_LENGTH;
            end else begin
              acc_nxt = acc_pad;
              pad_nxt = 1'b1;
              pos_nxt = 2'd3;
            end
          end else if (!fin) begin
            job_push   = 1'b1;
            job.status = STS_BADPAD;
          end else begin
            job_push   = 1'b1;
            job.status = STS_DATA;
            job.data   = acc_pad;
            job.nres   = (dchars_r >= 3'd3) ? 2'd2 : 2'd1;
          end
        end else if (pad_r) begin
          job_push   = 1'b1;
          job.status = STS_BADPAD;
        end else if (sx[6]) begin
          job_push   = 1'b1;
          job.status = STS_INVALID;
        end else if (pos_r == 2'd3) begin
          job_push   = 1'b1;
          job.status = STS_DATA;
          job.data   = acc_dat;
          job.nres   = 2'd3;
        end else if (fin) begin
          job_push   = 1'b1;
          job.status = STS_LENGTH;
        end else begin
          acc_nxt    = acc_dat;
          dchars_nxt = dchars_r + 3'd1;
          pos_nxt    = pos_r + 2'd1;
        end

        // Any result ends the quantum; an error also starts a drop unless final.
        if (job_push) begin
          acc_nxt    = '0;
          pos_nxt    = '0;
          dchars_nxt = '0;
          pad_nxt    = 1'b0;
          if (job.status != STS_DATA) begin
            job.nres = 2'd1;
            drop_nxt = !fin;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      pos_r    <= '0;
      dchars_r <= '0;
      pad_r    <= 1'b0;
      drop_r   <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      pos_r    <= pos_nxt;
      dchars_r <= dchars_nxt;
      pad_r    <= pad_nxt;
      drop_r   <= drop_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      empty,
  output logic      full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  always_comb begin
    empty   = (cnt_r == '0);
    full    = (cnt_r == CW'(DEPTH));
    head    = mem_r[rp_r];
    do_push = push && !full;
    do_pop  = pop && !empty;
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64d_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module b64d_back
  import b64d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire job_t head,
  input  wire logic head_valid,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic [1:0] k_r, k_nxt;
  logic       ov_r, ov_nxt;
  out_t       od_r, od_nxt;
  logic       load;
  logic       last;
  logic [7:0] sel;

  always_comb begin
    load = !ov_r || out_ready;
    last = (k_r + 2'd1 == head.nres);
    unique case (k_r)
      2'd0:    sel = head.data[23:16];
      2'd1:    sel = head.data[15:8];
      default: sel = head.data[7:0];
    endcase

    pop    = 1'b0;
    k_nxt  = k_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    if (load) begin
      ov_nxt = head_valid;
      if (head_valid) begin
        od_nxt.status   = head.status;
        od_nxt.out_byte = (head.status == STS_DATA) ? sel : 8'd0;
        od_nxt.run_last = last;
        if (last) begin
          pop   = 1'b1;
          k_nxt = 2'd0;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
    end
    out_valid = ov_r;
    out_data  = od_r;
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r  <= '0;
      ov_r <= 1'b0;
    end else begin
      k_r  <= k_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/base64_stream_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Streaming base64 decoder for the standard alphabet with '=' padding. One
// character is taken per request, and a request can be accepted in every cycle
// while the job queue has room. The front end classifies each character and
// updates the quantum state in the same cycle it is accepted; a character that
// completes a quantum, or that is in error, pushes one job into a short queue.
// The back end turns a job into one, two or three results, one per cycle while
// the receiver takes them, into an output register. The first result of a job
// passes through the job queue and then the output register. Errors give a
// single status result with a zero byte, after which characters are dropped
// through the next final one unless the erring character was itself final.
// Sustained input rate is one character per cycle; when the output side stalls,
// the job queue fills and in_ready holds the input back.
module base64_stream_decoder_top
  import b64d_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  job_t job;
  logic job_push;
  job_t head;
  logic q_empty;
  logic q_full;
  logic pop;

  // The front end never stalls except on a full queue.
  assign in_ready = !q_full;

  b64d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_valid && in_ready),
    .item     (in_data),
    .job      (job),
    .job_push (job_push)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef ASSERT_OFF
  // A status result is always alone and carries a zero byte.
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STS_DATA |->
      out_data.out_byte == 8'd0 && out_data.run_last)
    else $error("status result with data byte or without run_last");

  // Bytes of one quantum follow each other without a gap.
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.run_last |=>
      out_valid && out_data.status == STS_DATA)
    else $error("quantum bytes interrupted");

  // A job never pops from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty job queue");
`endif

endmodule
`default_nettype wire

// ===== dv/base64_stream_decoder_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the streaming base64 decoder. Characters go in as
// requests on the input channel; every accepted request is run through a
// behavioral decoder kept in this module, and the bytes or status codes it
// produces, or the typed results of its row, are queued. Each result taken
// from the output channel must match the oldest queued entry field by field.
module base64_stream_decoder_top_test;
  import b64d_pkg::*;

  localparam int CLK_HALF_NS = 10;
  localparam int TIMEOUT_NS = 4_000_000;
  localparam int RANDOM_PER_PHASE = 78;
  localparam int DRAIN_CYCLES = 30;
  localparam int MAX_REPORTS = 10;

  // Standard alphabet, first character in the top byte.
  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One stimulus row. When has_typed is set, the expected results are the
  // typed ones instead of what the behavioral decoder works out.
  typedef struct packed {
    in_t        item;
    logic       has_typed;
    logic [1:0] typed_count;
    out_t [2:0] typed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Idle rates in percent; the receiver rate is updated by nonblocking
  // assignment so the receiver process always sees a stable value.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  int fail_count = 0;

  stim_row_t stim_rows[$];
  out_t      pending_results[$];

  // Decoder state mirrored from the block's behavior.
  logic [23:0] quantum_bits = '0;
  logic [1:0]  quantum_pos = '0;
  logic [2:0]  quantum_chars = '0;
  logic        quantum_padded = 1'b0;
  logic        skip_to_end = 1'b0;

  base64_stream_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #TIMEOUT_NS;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic out_t status_res(input logic [1:0] code);
    return out_t'{out_byte: 8'h00, status: code, run_last: 1'b1};
  endfunction

  function automatic out_t data_res(input logic [7:0] b, input logic last);
    return out_t'{out_byte: b, status: STS_DATA, run_last: last};
  endfunction

  function automatic void report_failure(input string msg);
    if (fail_count < MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    fail_count++;
  endfunction

  // Position of a character in the alphabet, or -1 when it is not in it.
  function automatic int alphabet_index(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (B64_ALPHABET[8*(63-i) +: 8] == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  task automatic restart_quantum();
    quantum_bits = '0;
    quantum_pos = '0;
    quantum_chars = '0;
    quantum_padded = 1'b0;
  endtask

  // Behavioral decoder: advances the mirrored state by one character and
  // returns the results that character causes, oldest in res[0].
  task automatic predict_decode(input in_t item, output out_t [2:0] res, output int n);
    int         idx;
    int         n_bytes;
    logic [1:0] err;
    res = '0;
    n = 0;
    n_bytes = 0;
    err = STS_DATA;
    if (skip_to_end) begin
      // After an error everything through the next final character is dropped.
      if (item.text_end) begin
        skip_to_end = 1'b0;
        restart_quantum();
      end
    end else if (item.char_code == PAD_CHAR) begin
      if (quantum_pos < 2'd2) begin
        err = STS_BADPAD;
      end else if (quantum_pos == 2'd2) begin
        // A pad in the third slot must be followed by a second pad.
        if (item.text_end) begin
          err = STS_LENGTH;
        end else begin
          quantum_bits = {quantum_bits[17:0], 6'd0};
          quantum_padded = 1'b1;
          quantum_pos = 2'd3;
        end
      end else if (!item.text_end) begin
        err = STS_BADPAD;
      end else begin
        quantum_bits = {quantum_bits[17:0], 6'd0};
        n_bytes = (quantum_chars >= 3'd3) ? 2 : 1;
      end
    end else begin
      idx = alphabet_index(item.char_code);
      // Anything but a pad after a pad is a padding error, even a bad byte.
      if (quantum_padded) begin
        err = STS_BADPAD;
      end else if (idx < 0) begin
        err = STS_INVALID;
      end else begin
        quantum_bits = {quantum_bits[17:0], 6'(idx)};
        quantum_chars = quantum_chars + 3'd1;
        if (quantum_pos == 2'd3) begin
          n_bytes = 3;
        end else begin
          quantum_pos = quantum_pos + 2'd1;
          if (item.text_end) begin
            err = STS_LENGTH;
          end
        end
      end
    end
    if (err != STS_DATA) begin
      restart_quantum();
      skip_to_end = !item.text_end;
      res[0] = status_res(err);
      n = 1;
    end else if (n_bytes > 0) begin
      for (int k = 0; k < n_bytes; k++) begin
        res[k] = data_res(quantum_bits[23-8*k -: 8], k == n_bytes - 1);
      end
      restart_quantum();
      n = n_bytes;
    end
  endtask

  // Queue one row. A negative count means the behavioral decoder decides.
  task automatic add_row(input logic [7:0] c, input logic e, input int n,
                         input out_t r0 = '0, input out_t r1 = '0,
                         input out_t r2 = '0);
    stim_row_t row;
    row = '0;
    row.item = in_t'{char_code: c, text_end: e};
    row.has_typed = (n >= 0);
    row.typed_count = (n >= 0) ? 2'(n) : 2'd0;
    row.typed[0] = r0;
    row.typed[1] = r1;
    row.typed[2] = r2;
    stim_rows = {stim_rows, row};
  endtask

  // Queue one random text. Most texts are well formed with random content and
  // random padding; some are broken on purpose, and a few are raw noise.
  task automatic queue_random_text();
    logic [7:0] chars[$];
    int         mode;
    int         nq;
    int         pad;
    int         pos;
    mode = $urandom_range(99);
    if (mode < 85) begin
      nq = $urandom_range(1, 3);
      pad = $urandom_range(0, 2);
      for (int i = 0; i < nq * 4; i++) begin
        chars = {chars, B64_ALPHABET[8*$urandom_range(0, 63) +: 8]};
      end
      if (pad >= 1) chars[chars.size() - 1] = PAD_CHAR;
      if (pad == 2) chars[chars.size() - 2] = PAD_CHAR;
      if (mode >= 70) begin
        pos = $urandom_range(0, chars.size() - 1);
        case ($urandom_range(0, 3))
          0: chars[pos] = 8'($urandom_range(0, 255));
          1: chars[pos] = PAD_CHAR;
          2: chars.insert(pos, 8'($urandom_range(0, 255)));
          default: begin
            // Cut the text short so the final character lands mid-quantum.
            while (chars.size() > pos + 1) void'(chars.pop_back());
          end
        endcase
      end
      for (int i = 0; i < chars.size(); i++) begin
        add_row(chars[i], i == chars.size() - 1, -1);
      end
    end else begin
      nq = $urandom_range(1, 6);
      for (int i = 0; i < nq; i++) begin
        add_row(8'($urandom_range(0, 255)),
                (i == nq - 1) || ($urandom_range(0, 3) == 0), -1);
      end
    end
  endtask

  // Offer every queued row as a request. The valid line is only dropped when
  // an idle gap is drawn, so back-to-back requests keep it high.
  task automatic send_rows();
    stim_row_t  row;
    out_t [2:0] res;
    int         n;
    while (stim_rows.size() > 0) begin
      row = stim_rows.pop_front();
      while ($urandom_range(0, 99) < sender_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= row.item;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      // The request was taken at this edge.
      predict_decode(row.item, res, n);
      if (row.has_typed) begin
        res = row.typed;
        n = row.typed_count;
      end
      for (int k = 0; k < n; k++) begin
        pending_results = {pending_results, res[k]};
      end
    end
  endtask

  // Receiver: draws ready each cycle and checks every result it takes.
  always @(posedge clk) begin : result_check
    out_t want;
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result byte=%02h status=%0d last=%0b",
                                 out_data.out_byte, out_data.status, out_data.run_last));
      end else begin
        want = pending_results.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.status !== want.status ||
            out_data.run_last !== want.run_last) begin
          report_failure($sformatf(
            "expected byte=%02h status=%0d last=%0b, got byte=%02h status=%0d last=%0b",
            want.out_byte, want.status, want.run_last,
            out_data.out_byte, out_data.status, out_data.run_last));
        end
      end
    end
  end

  initial begin
    // Directed texts: extreme bytes, every status code and each padding rule.
    add_row(8'h00, 1'b1, 1, status_res(STS_INVALID));
    // "////" decodes to three all-ones bytes.
    add_row("/", 1'b0, -1);
    add_row("/", 1'b0, -1);
    add_row("/", 1'b0, -1);
    add_row("/", 1'b1, 3, data_res(8'hFF, 1'b0), data_res(8'hFF, 1'b0),
            data_res(8'hFF, 1'b1));
    // Double padding gives a single zero byte.
    add_row("A", 1'b0, -1);
    add_row("A", 1'b0, -1);
    add_row(PAD_CHAR, 1'b0, -1);
    add_row(PAD_CHAR, 1'b1, 1, data_res(8'h00, 1'b1));
    // Single padding gives two bytes.
    add_row("T", 1'b0, -1);
    add_row("W", 1'b0, -1);
    add_row("E", 1'b0, -1);
    add_row(PAD_CHAR, 1'b1, -1);
    // Pad in the second slot is too early.
    add_row("Q", 1'b0, -1);
    add_row(PAD_CHAR, 1'b1, 1, status_res(STS_BADPAD));
    // Text ending on a pad in the third slot is short.
    add_row("A", 1'b0, -1);
    add_row("B", 1'b0, -1);
    add_row(PAD_CHAR, 1'b1, 1, status_res(STS_LENGTH));
    // A bad byte after a pad still counts as a padding error.
    add_row("Q", 1'b0, -1);
    add_row("R", 1'b0, -1);
    add_row(PAD_CHAR, 1'b0, -1);
    add_row(8'hFF, 1'b1, 1, status_res(STS_BADPAD));
    // Pad in the last slot without the final flag, then the dropped tail.
    add_row("a", 1'b0, -1);
    add_row("b", 1'b0, -1);
    add_row("c", 1'b0, -1);
    add_row(PAD_CHAR, 1'b0, 1, status_res(STS_BADPAD));
    add_row("9", 1'b1, 0);
    // One data character alone is a short text.
    add_row("A", 1'b1, 1, status_res(STS_LENGTH));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_rows();

    // Random texts under each idling pattern in turn.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct <= 0;
        end
        1: begin
          sender_idle_pct = 84;
          receiver_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct <= 84;
        end
        default: begin
          sender_idle_pct = 7;
          receiver_stall_pct <= 7;
        end
      endcase
      while (stim_rows.size() < RANDOM_PER_PHASE) queue_random_text();
      send_rows();
    end
    in_valid <= 1'b0;

    // Drain, then give any stray result time to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
